// File: src/sorted_priority_queue_unit_macros.svh
// assertion macros for the sorted priority queue unit
// no dependencies; included by sorted_priority_queue_unit, the module that carries assertions
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while in reset
`define SPQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled while in reset
`define SPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define SPQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define SPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: src/spq_pkg.sv
// shared types and constants for the sorted priority queue unit
// no dependencies
package spq_pkg;

    // fixed field widths of the stream transactions
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 40;

    // transaction kind carried on s_axis_tuser
    typedef enum logic {
        MODE_PUSH = 1'b0,
        MODE_POP  = 1'b1
    } spq_mode_t;

    // result status carried on m_axis_tuser
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } spq_status_t;

    // operation broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } spq_op_t;

endpackage

// File: src/sorted_priority_queue_unit.sv
// top level of the sorted priority queue unit: control, cell chain, result register
// depends on spq_pkg, spq_cell and sorted_priority_queue_unit_macros.svh
//
// Max priority queue of up to DEPTH unsigned values held in a chain of cells
// sorted in descending order, so the largest entry always sits in cell 0.
// Each input transaction is a push (s_axis_tuser = 0, value in s_axis_tdata)
// or a pop (s_axis_tuser = 1) and gives exactly one result transaction with
// the largest value after the operation (zero when empty), the entry count,
// an empty flag and a status (0 ok, 1 push refused because full, 2 pop
// refused because empty); a refused operation leaves the contents unchanged.
// Every cell compares against the incoming value in parallel and takes its
// new content from itself, the input or a neighbor, so one transaction is
// taken per clock while the output register can accept it. The result is
// registered in the output register in the cycle after acceptance; input is
// taken whenever that register is empty or being drained in the same cycle.
// Values are kept to their low VALUE_WIDTH bits.
`include "sorted_priority_queue_unit_macros.svh"

module sorted_priority_queue_unit import spq_pkg::*; #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,  // [31:0] value
    input  logic                s_axis_tuser,  // [0] mode
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,  // [31:0] top_value, [36:32] entry_count,
                                               // [37] is_empty, [39:38] zero
    output logic [STATUS_W-1:0] m_axis_tuser   // [1:0] status
);

    localparam int VW    = (VALUE_WIDTH < VALUE_W) ? VALUE_WIDTH : VALUE_W;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]    count_reg, count_next;
    logic                m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0]  top_reg, top_next;
    logic [COUNT_W-1:0]  cnt_out_reg, cnt_out_next;
    logic                empty_reg, empty_next;
    spq_status_t         status_reg, status_next;

    logic                s_accept;
    logic                is_full;
    logic                is_none;
    logic [VW-1:0]       in_value;
    spq_op_t             op;

    logic [VW-1:0]       cell_val [DEPTH];
    logic                cell_ge  [DEPTH];

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign in_value      = s_axis_tdata[VW-1:0];
    assign is_full       = count_reg == CNT_W'(DEPTH);
    assign is_none       = count_reg == '0;

    // operation that the cells carry out this cycle
    always_comb begin
        op.push = s_accept && (s_axis_tuser == MODE_PUSH) && !is_full;
        op.pop  = s_accept && (s_axis_tuser == MODE_POP) && !is_none;
    end

    // chain of cells, cell 0 holds the largest entry
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic          up_ge;
        logic [VW-1:0] up_value;
        logic [VW-1:0] down_value;

        if (i == 0) begin : g_first
            assign up_ge    = 1'b1;
            assign up_value = cell_val[i];
        end else begin : g_mid
            assign up_ge    = cell_ge[i-1];
            assign up_value = cell_val[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign down_value = cell_val[i];
        end else begin : g_inner
            assign down_value = cell_val[i+1];
        end

        spq_cell #(
            .VW       (VW),
            .CNT_W    (CNT_W),
            .CELL_IDX (i)
        ) u_cell (
            .aclk       (aclk),
            .op         (op),
            .new_value  (in_value),
            .count      (count_reg),
            .up_ge      (up_ge),
            .up_value   (up_value),
            .down_value (down_value),
            .ge         (cell_ge[i]),
            .value      (cell_val[i])
        );
    end

    // fill level, result and output register control
    always_comb begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        top_next     = top_reg;
        cnt_out_next = cnt_out_reg;
        empty_next   = empty_reg;
        status_next  = status_reg;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        if (s_accept) begin
            m_valid_next = 1'b1;
            status_next  = ST_OK;
            top_next     = is_none ? '0 : VALUE_W'(cell_val[0]);
            if (s_axis_tuser == MODE_PUSH) begin
                if (is_full) begin
                    status_next = ST_FULL;
                end else begin
                    count_next = count_reg + 1'b1;
                    top_next   = cell_ge[0] ? VALUE_W'(cell_val[0]) : VALUE_W'(in_value);
                end
            end else begin
                if (is_none) begin
                    status_next = ST_EMPTY;
                end else begin
                    count_next = count_reg - 1'b1;
                    top_next   = (count_reg == CNT_W'(1)) ? '0 : VALUE_W'(cell_val[1]);
                end
            end
            cnt_out_next = COUNT_W'(count_next);
            empty_next   = count_next == '0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload registers
    always_ff @(posedge aclk) begin
        top_reg     <= top_next;
        cnt_out_reg <= cnt_out_next;
        empty_reg   <= empty_next;
        status_reg  <= status_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00, empty_reg, cnt_out_reg, top_reg};
    assign m_axis_tuser  = status_reg;

    // checks
    `SPQ_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH))
    `SPQ_ASSERT_NEXT(a_push_grows, aclk, aresetn, op.push, count_reg == $past(count_reg) + 1'b1)
    `SPQ_ASSERT_NEXT(a_pop_shrinks, aclk, aresetn, op.pop, count_reg == $past(count_reg) - 1'b1)
    `SPQ_ASSERT_NEXT(a_refused_hold, aclk, aresetn, s_accept && !op.push && !op.pop, $stable(count_reg))
    `SPQ_ASSERT_IMPL(a_empty_top_zero, aclk, aresetn, m_valid_reg && empty_reg, top_reg == '0)

endmodule

// File: src/spq_cell.sv
// one storage cell of the descending chain; cell 0 holds the largest entry
// depends on spq_pkg
module spq_cell import spq_pkg::*; #(
    parameter int VW       = 32,
    parameter int CNT_W    = 5,
    parameter int CELL_IDX = 0
) (
    input  logic             aclk,
    input  spq_op_t          op,
    input  logic [VW-1:0]    new_value,
    input  logic [CNT_W-1:0] count,
    input  logic             up_ge,
    input  logic [VW-1:0]    up_value,
    input  logic [VW-1:0]    down_value,
    output logic             ge,
    output logic [VW-1:0]    value
);

    logic [VW-1:0] value_reg;
    logic [VW-1:0] value_next;
    logic          occupied;

    // entry counts as present only below the fill level
    assign occupied = CNT_W'(CELL_IDX) < count;
    assign ge       = occupied && (value_reg >= new_value);
    assign value    = value_reg;

    // keep, take the new value, or shift one place: away from the top on a push, toward it on a pop
    always_comb begin
        value_next = value_reg;
        if (op.push) begin
            if (ge) begin
                value_next = value_reg;
            end else if (up_ge) begin
                value_next = new_value;
            end else begin
                value_next = up_value;
            end
        end else if (op.pop) begin
            value_next = down_value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

// File: sim/spq_scoreboard_pkg.sv
`timescale 1ns / 1ps
// scoreboard for the sorted priority queue unit: max-queue predictor and result checker
// depends on spq_pkg
package spq_scoreboard_pkg;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_REPORTS = 20;

    // one expected result transaction
    typedef struct packed {
        logic [VALUE_W-1:0] top_value;
        logic [COUNT_W-1:0] entry_count;
        logic               is_empty;
        spq_status_t        status;
    } queue_result_t;

    class queue_scoreboard;
        logic [VALUE_W-1:0] sorted_vals [QUEUE_DEPTH];  // ascending, valid below held
        int unsigned        held;
        queue_result_t      expected_q [$];
        int                 errors;
        int                 n_push;
        int                 n_pop;
        int                 n_full_refused;
        int                 n_empty_refused;
        int                 n_results;
        int unsigned        max_held;

        function new();
            held            = 0;
            errors          = 0;
            n_push          = 0;
            n_pop           = 0;
            n_full_refused  = 0;
            n_empty_refused = 0;
            n_results       = 0;
            max_held        = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // predict the result of an accepted input transaction
        function void note_request(spq_mode_t mode, logic [VALUE_W-1:0] value);
            queue_result_t res;
            int unsigned   pos;
            res.status = ST_OK;
            if (mode == MODE_PUSH) begin
                n_push++;
                if (held >= QUEUE_DEPTH) begin
                    res.status = ST_FULL;
                    n_full_refused++;
                end else begin
                    // equal values go below the ones already stored
                    pos = 0;
                    while (pos < held && sorted_vals[pos] < value)
                        pos++;
                    for (int k = held; k > pos; k--)
                        sorted_vals[k] = sorted_vals[k-1];
                    sorted_vals[pos] = value;
                    held++;
                end
            end else begin
                n_pop++;
                if (held == 0) begin
                    res.status = ST_EMPTY;
                    n_empty_refused++;
                end else begin
                    held--;
                end
            end
            if (held > max_held)
                max_held = held;
            res.top_value   = (held != 0) ? sorted_vals[held-1] : '0;
            res.entry_count = COUNT_W'(held);
            res.is_empty    = (held == 0);
            expected_q.push_back(res);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        // compare one accepted result transaction with the oldest prediction
        task check_result(logic [M_DATA_W-1:0] tdata, logic [STATUS_W-1:0] tuser);
            queue_result_t want;
            n_results++;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result with nothing outstanding, tdata %h", tdata));
                return;
            end
            want = expected_q.pop_front();
            if (tdata[31:0] !== want.top_value)
                report_mismatch($sformatf("result %0d top_value %h, want %h",
                    n_results, tdata[31:0], want.top_value));
            if (tdata[36:32] !== want.entry_count)
                report_mismatch($sformatf("result %0d entry_count %0d, want %0d",
                    n_results, tdata[36:32], want.entry_count));
            if (tdata[37] !== want.is_empty)
                report_mismatch($sformatf("result %0d is_empty %b, want %b",
                    n_results, tdata[37], want.is_empty));
            if (tuser !== want.status)
                report_mismatch($sformatf("result %0d status %0d, want %0d",
                    n_results, tuser, want.status));
        endtask
    endclass

endpackage

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// testbench top for the sorted priority queue unit: stream drivers, monitor, stimulus
// depends on spq_pkg, spq_scoreboard_pkg and the unit under test
module tb_top;
    import spq_pkg::*;
    import spq_scoreboard_pkg::*;

    localparam int RANDOM_ITEMS = 1350;
    localparam int CALM_FROM    = 1150;
    localparam int CYCLE_LIMIT  = 200000;

    logic                aclk;
    logic                aresetn;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;
    logic                s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0] m_axis_tuser;

    logic                tx_idle_on;
    logic                rx_idle_on;
    int                  cycles;
    logic [VALUE_W-1:0]  dup_pool [4];

    queue_scoreboard sb = new();

    sorted_priority_queue_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d results outstanding",
                    cycles, sb.pending());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // monitor: note accepted inputs, check accepted results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(spq_mode_t'(s_axis_tuser), s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // result side backpressure in bursts
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                stall = $urandom_range(1, 6);
                repeat (stall - 1) @(negedge aclk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // hold the input channel idle for a gap
    task automatic sender_gap(int n);
        repeat (n) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
        end
    endtask

    // present one transaction and wait for it to be taken
    task automatic send_op(spq_mode_t mode, logic [VALUE_W-1:0] value);
        if (tx_idle_on && $urandom_range(0, 3) == 0)
            sender_gap($urandom_range(1, 6));
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= value;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // stop sending until every outstanding result is back
    task automatic wait_drained();
        sender_gap(1);
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    // value mix: wide random, duplicates from a small pool, extremes
    function automatic logic [VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return $urandom();
        else if (sel < 8)
            return dup_pool[$urandom_range(0, 3)];
        else begin
            case ($urandom_range(0, 3))
                0: return 32'h0000_0000;
                1: return 32'hFFFF_FFFF;
                2: return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
    endfunction

    // stimulus
    initial begin
        int ep_left;
        int push_pct;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_PUSH;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: pop when empty, extremes and equal values, fill, push when full, then pops
        send_op(MODE_POP, 32'hA5A5_5A5A);
        send_op(MODE_PUSH, 32'h0000_0000);
        send_op(MODE_PUSH, 32'hFFFF_FFFF);
        send_op(MODE_PUSH, 32'hFFFF_FFFF);
        send_op(MODE_PUSH, 32'h0000_0000);
        send_op(MODE_PUSH, 32'h8000_0000);
        send_op(MODE_PUSH, 32'h7FFF_FFFF);
        send_op(MODE_PUSH, 32'h0000_0001);
        for (int k = 0; k < 9; k++)
            send_op(MODE_PUSH, $urandom());
        send_op(MODE_PUSH, 32'hFFFF_FFFF);
        send_op(MODE_PUSH, 32'h0000_0000);
        for (int k = 0; k < 5; k++)
            send_op(MODE_POP, $urandom());
        wait_drained();

        // random: episodes that fill, drain, churn or hover near full
        ep_left  = 0;
        push_pct = 50;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (ep_left == 0) begin
                ep_left = $urandom_range(20, 80);
                case ($urandom_range(0, 3))
                    0: push_pct = 85;
                    1: push_pct = 15;
                    2: push_pct = 50;
                    default: push_pct = 62;
                endcase
                foreach (dup_pool[j])
                    dup_pool[j] = $urandom();
            end
            ep_left--;
            if (i == RANDOM_ITEMS / 2)
                wait_drained();
            if (i == CALM_FROM) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            if ($urandom_range(1, 100) <= push_pct)
                send_op(MODE_PUSH, pick_value());
            else
                send_op(MODE_POP, $urandom());
        end

        // wind down
        wait_drained();
        repeat (4) @(posedge aclk);
        $display("covered %0d pushes and %0d pops, %0d refused when full, %0d when empty",
            sb.n_push, sb.n_pop, sb.n_full_refused, sb.n_empty_refused);
        $display("checked %0d results, peak fill %0d of %0d, %0d mismatches",
            sb.n_results, sb.max_held, QUEUE_DEPTH, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
